// File: design/m3inv_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the 3x3 matrix inverse block.
package m3inv_pkg;

    localparam int ELEM_W = 32;
    localparam int PROD_W = 64;
    localparam int DEN_W  = 96;
    localparam int QUO_W  = 33;
    localparam int THR_W  = 31;
    localparam int NELEM  = 9;

    localparam logic [THR_W-1:0] THR_RESET = 31'd1;

    localparam logic [QUO_W-1:0] LIM_POS = 33'h0_7FFF_FFFF;
    localparam logic [QUO_W-1:0] LIM_NEG = 33'h0_8000_0000;

    // minor k (adjugate order) = e[p]*e[s] - e[q]*e[r], listed as {p, s, q, r}
    localparam int MINOR_IDX [NELEM][4] = '{
        '{4, 8, 5, 7}, '{1, 8, 2, 7}, '{1, 5, 2, 4},
        '{3, 8, 5, 6}, '{0, 8, 2, 6}, '{0, 5, 2, 3},
        '{3, 7, 4, 6}, '{0, 7, 1, 6}, '{0, 4, 1, 3}
    };

    // cofactors that take a minus sign in the adjugate
    localparam logic [NELEM-1:0] ADJ_NEG = 9'h0AA;

    typedef struct packed {
        logic signed [ELEM_W-1:0] a11, a12, a13;
        logic signed [ELEM_W-1:0] a21, a22, a23;
        logic signed [ELEM_W-1:0] a31, a32, a33;
    } matrix_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] r11, r12, r13;
        logic signed [ELEM_W-1:0] r21, r22, r23;
        logic signed [ELEM_W-1:0] r31, r32, r33;
        logic                     singular;
        logic                     saturated;
    } result_t;

    typedef struct packed {
        logic [NELEM-1:0][PROD_W-1:0] adj;
        logic [DEN_W-1:0]             den;
        logic                         det_neg;
        logic                         singular;
    } entry_t;

endpackage

// File: design/m3inv_fifo.sv
`timescale 1ns / 1ps
// Small register queue used between the pipeline sections and at the output.
module m3inv_fifo #(
    parameter int  DEPTH = 2,
    parameter type T     = logic
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  T     wdata,
    input  logic pop,
    output T     rdata,
    output logic empty,
    output logic full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    T                 mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(DEPTH));

endmodule

// File: design/m3inv_front.sv
`timescale 1ns / 1ps
// Front section: minors, determinant and singular classification.
module m3inv_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  m3inv_pkg::matrix_t                  in_matrix,
    input  logic [m3inv_pkg::THR_W-1:0]         threshold,
    output logic                                out_valid,
    output m3inv_pkg::entry_t                   out_entry
);

    localparam int EW     = m3inv_pkg::ELEM_W;
    localparam int PW     = m3inv_pkg::PROD_W;
    localparam int DW     = m3inv_pkg::DEN_W;
    localparam int NE     = m3inv_pkg::NELEM;
    localparam int NST    = 7;
    localparam int TERM_W = 97;
    localparam int DET_W  = 98;

    logic [NST-1:0] valid_reg;

    logic signed [EW-1:0]     elem_reg [6][NE];
    logic signed [EW-1:0]     elem_in [NE];
    logic signed [PW-1:0]     prod_reg [2*NE], prod_next [2*NE];
    logic signed [PW-1:0]     adj_reg [4][NE];
    logic signed [PW-1:0]     adj_next [NE];
    logic signed [PW-1:0]     ph_reg [3], ph_next [3];
    logic signed [PW:0]       pl_reg [3], pl_next [3];
    logic signed [TERM_W-1:0] term_reg [3], term_next [3];
    logic signed [DET_W-1:0]  det_reg, det_next;
    logic [DET_W-1:0]         det_mag;
    logic [DET_W-1:0]         thr_lim;
    logic                     is_sing;
    m3inv_pkg::entry_t        entry_reg, entry_next;

    assign elem_in = '{in_matrix.a11, in_matrix.a12, in_matrix.a13,
                       in_matrix.a21, in_matrix.a22, in_matrix.a23,
                       in_matrix.a31, in_matrix.a32, in_matrix.a33};

    always_comb
    begin
        for (int k = 0; k < NE; k++)
        begin
            prod_next[2*k]   = elem_reg[0][m3inv_pkg::MINOR_IDX[k][0]]
                             * elem_reg[0][m3inv_pkg::MINOR_IDX[k][1]];
            prod_next[2*k+1] = elem_reg[0][m3inv_pkg::MINOR_IDX[k][2]]
                             * elem_reg[0][m3inv_pkg::MINOR_IDX[k][3]];
            adj_next[k] = m3inv_pkg::ADJ_NEG[k] ? prod_reg[2*k+1] - prod_reg[2*k]
                                                : prod_reg[2*k] - prod_reg[2*k+1];
        end
        // det = a11*adj11 + a21*adj12 + a31*adj13, each 32x64 product split in two
        for (int j = 0; j < 3; j++)
        begin
            ph_next[j]   = elem_reg[2][3*j] * $signed(adj_reg[0][j][PW-1:32]);
            pl_next[j]   = elem_reg[2][3*j] * $signed({1'b0, adj_reg[0][j][31:0]});
            term_next[j] = TERM_W'($signed({ph_reg[j], 32'b0})) + TERM_W'(pl_reg[j]);
        end
        det_next = DET_W'(term_reg[0]) + DET_W'(term_reg[1]) + DET_W'(term_reg[2]);

        det_mag = det_reg[DET_W-1] ? DET_W'(-det_reg) : DET_W'(det_reg);
        thr_lim = DET_W'(threshold) << (2 * FRAC_BITS);
        is_sing = (det_mag <= thr_lim);

        // a singular matrix rides through the divider as itself over 2^(2F)
        entry_next.singular = is_sing;
        entry_next.det_neg  = !is_sing && det_reg[DET_W-1];
        entry_next.den      = is_sing ? (DW'(1) << (2 * FRAC_BITS)) : det_mag[DW-1:0];
        for (int k = 0; k < NE; k++)
        begin
            entry_next.adj[k] = is_sing ? PW'(elem_reg[5][k]) : adj_reg[3][k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            elem_reg[0] <= elem_in;
            for (int s = 1; s < 6; s++)
            begin
                elem_reg[s] <= elem_reg[s-1];
            end
            prod_reg   <= prod_next;
            adj_reg[0] <= adj_next;
            for (int s = 1; s < 4; s++)
            begin
                adj_reg[s] <= adj_reg[s-1];
            end
            ph_reg    <= ph_next;
            pl_reg    <= pl_next;
            term_reg  <= term_next;
            det_reg   <= det_next;
            entry_reg <= entry_next;
        end
    end

    assign out_valid = valid_reg[NST-1];
    assign out_entry = entry_reg;

endmodule

// File: design/m3inv_div_lane.sv
`timescale 1ns / 1ps
// One pipelined restoring divider lane with rounding and saturation.
module m3inv_div_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [m3inv_pkg::PROD_W-1:0] adj,
    input  logic [m3inv_pkg::DEN_W-1:0]         den,
    input  logic                                det_neg,
    output logic [m3inv_pkg::ELEM_W-1:0]        value,
    output logic                                sat
);

    localparam int QW    = m3inv_pkg::QUO_W;
    localparam int DW    = m3inv_pkg::DEN_W;
    localparam int PW    = m3inv_pkg::PROD_W;
    localparam int EW    = m3inv_pkg::ELEM_W;
    localparam int NUM_W = PW + 2 * FRAC_BITS + 1;
    localparam int HI_W  = NUM_W - QW;

    logic [DW-1:0] rem_reg [QW+1], rem_next [QW+1];
    logic [DW-1:0] den_reg [QW+1], den_next [QW+1];
    logic [QW-1:0] low_reg [QW+1], low_next [QW+1];
    logic [QW-1:0] quo_reg [QW+1], quo_next [QW+1];
    logic [QW:0]   sat0_reg, sat0_next;
    logic [QW:0]   neg_reg, neg_next;
    logic [DW:0]   trial [QW];
    logic [QW-1:0] take;

    logic [PW-1:0]    mag;
    logic [NUM_W-1:0] num;
    logic [HI_W-1:0]  hi;
    logic [QW:0]      tp1;
    logic [QW-1:0]    rq, lim, clamp;
    logic             over;
    logic [EW-1:0]    value_reg, value_next;
    logic             sat_reg, sat_next;

    always_comb
    begin
        mag = adj[PW-1] ? PW'(-adj) : PW'(adj);
        num = NUM_W'(mag) << (2 * FRAC_BITS + 1);
        hi  = num[NUM_W-1:QW];

        // quotient already needs more than QW bits: clamp at the end
        sat0_next[0] = (DW'(hi) >= den);
        rem_next[0]  = sat0_next[0] ? '0 : DW'(hi);
        low_next[0]  = num[QW-1:0];
        quo_next[0]  = '0;
        neg_next[0]  = adj[PW-1] ^ det_neg;
        den_next[0]  = den;

        for (int k = 1; k <= QW; k++)
        begin
            trial[k-1]   = {rem_reg[k-1], low_reg[k-1][QW-1]};
            take[k-1]    = (trial[k-1] >= {1'b0, den_reg[k-1]});
            rem_next[k]  = take[k-1] ? DW'(trial[k-1] - {1'b0, den_reg[k-1]})
                                     : trial[k-1][DW-1:0];
            low_next[k]  = low_reg[k-1] << 1;
            quo_next[k]  = {quo_reg[k-1][QW-2:0], take[k-1]};
            sat0_next[k] = sat0_reg[k-1];
            neg_next[k]  = neg_reg[k-1];
            den_next[k]  = den_reg[k-1];
        end

        // quotient holds 2*|adj|*2^(2F)/|det|; round half away from zero
        tp1   = {1'b0, quo_reg[QW]} + (QW+1)'(1);
        rq    = tp1[QW:1];
        lim   = neg_reg[QW] ? m3inv_pkg::LIM_NEG : m3inv_pkg::LIM_POS;
        over  = sat0_reg[QW] || (rq > lim);
        clamp = over ? lim : rq;
        value_next = neg_reg[QW] ? (~clamp[EW-1:0] + EW'(1)) : clamp[EW-1:0];
        sat_next   = over;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg   <= rem_next;
            den_reg   <= den_next;
            low_reg   <= low_next;
            quo_reg   <= quo_next;
            sat0_reg  <= sat0_next;
            neg_reg   <= neg_next;
            value_reg <= value_next;
            sat_reg   <= sat_next;
        end
    end

    assign value = value_reg;
    assign sat   = sat_reg;

endmodule

// File: design/m3inv_back.sv
`timescale 1ns / 1ps
// Back section: nine divider lanes that scale the adjugate by 1/det.
module m3inv_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  m3inv_pkg::entry_t   in_entry,
    output logic                out_valid,
    output m3inv_pkg::result_t  out_result
);

    localparam int LAT = m3inv_pkg::QUO_W + 2;
    localparam int NE  = m3inv_pkg::NELEM;
    localparam int EW  = m3inv_pkg::ELEM_W;

    logic [LAT-1:0] valid_reg;
    logic [LAT-1:0] sing_reg;
    logic [EW-1:0]  val [NE];
    logic [NE-1:0]  lane_sat;

    for (genvar g = 0; g < NE; g++)
    begin : g_lane
        m3inv_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk     (clk),
            .en      (en),
            .adj     ($signed(in_entry.adj[g])),
            .den     (in_entry.den),
            .det_neg (in_entry.det_neg),
            .value   (val[g]),
            .sat     (lane_sat[g])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[LAT-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sing_reg <= {sing_reg[LAT-2:0], in_entry.singular};
        end
    end

    assign out_valid            = valid_reg[LAT-1];
    assign out_result.r11       = val[0];
    assign out_result.r12       = val[1];
    assign out_result.r13       = val[2];
    assign out_result.r21       = val[3];
    assign out_result.r22       = val[4];
    assign out_result.r23       = val[5];
    assign out_result.r31       = val[6];
    assign out_result.r32       = val[7];
    assign out_result.r33       = val[8];
    assign out_result.singular  = sing_reg[LAT-1];
    assign out_result.saturated = |lane_sat;

endmodule

// File: design/matrix3x3_inverse_top.sv
`timescale 1ns / 1ps
// Throughput: one matrix per cycle while full is low; the divider lanes are fully pipelined.
// A full result queue stalls the divider section; a full middle queue stalls the front.
// Reset: rst_n low clears all queues and valid bits at once; the threshold returns to 1.
// Top level of the 3x3 matrix inverse block.
module matrix3x3_inverse_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            threshold_we,
    input  logic [m3inv_pkg::THR_W-1:0]     threshold,
    input  logic                            push,
    output logic                            full,
    input  m3inv_pkg::matrix_t              matrix,
    input  logic                            pop,
    output logic                            empty,
    output m3inv_pkg::result_t              result
);

    logic [m3inv_pkg::THR_W-1:0] thr_reg;

    logic               front_en;
    logic               front_valid;
    m3inv_pkg::entry_t  front_entry;
    logic               mid_empty;
    logic               mid_full;
    m3inv_pkg::entry_t  mid_entry;
    logic               back_en;
    logic               back_take;
    logic               back_valid;
    m3inv_pkg::result_t back_result;
    logic               res_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= m3inv_pkg::THR_RESET;
        end
        else if (threshold_we)
        begin
            thr_reg <= threshold;
        end
    end

    assign front_en  = !mid_full;
    assign back_en   = !res_full;
    assign back_take = back_en && !mid_empty;
    assign full      = mid_full;

    m3inv_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (front_en),
        .in_valid  (push),
        .in_matrix (matrix),
        .threshold (thr_reg),
        .out_valid (front_valid),
        .out_entry (front_entry)
    );

    m3inv_fifo #(
        .DEPTH (2),
        .T     (m3inv_pkg::entry_t)
    ) u_mid_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_en && front_valid),
        .wdata (front_entry),
        .pop   (back_take),
        .rdata (mid_entry),
        .empty (mid_empty),
        .full  (mid_full)
    );

    m3inv_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (back_en),
        .in_valid   (back_take),
        .in_entry   (mid_entry),
        .out_valid  (back_valid),
        .out_result (back_result)
    );

    m3inv_fifo #(
        .DEPTH (2),
        .T     (m3inv_pkg::result_t)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (back_en && back_valid),
        .wdata (back_result),
        .pop   (pop && !empty),
        .rdata (result),
        .empty (empty),
        .full  (res_full)
    );

endmodule

// File: design/m3inv_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the matrix inverse top level, with its bind.
module m3inv_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               full,
    input logic               pop,
    input logic               empty,
    input m3inv_pkg::result_t result
);

    // a passed-through singular matrix is never clamped
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(result.singular && result.saturated))
    else $error("singular result flagged as saturated");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> !empty)
    else $error("waiting result beat dropped");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> $stable(result))
    else $error("waiting result beat changed");

    // queues come out of reset drained
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> (empty && !full))
    else $error("queues not cleared by reset");

endmodule

bind matrix3x3_inverse_top m3inv_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .full   (full),
    .pop    (pop),
    .empty  (empty),
    .result (result)
);

// File: verif/matrix3x3_inverse_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the 3x3 matrix inverse block, with random flow control.
module matrix3x3_inverse_top_test;

    localparam int FB = 16;
    localparam logic [m3inv_pkg::THR_W-1:0] THR_MAX = 31'h7FFF_FFFF;

    class inverse_scoreboard;
        m3inv_pkg::result_t expected_q[$];
        logic [m3inv_pkg::THR_W-1:0] thr;
        int n_checked;
        int n_singular;
        int n_saturated;
        int n_errors;
        string elem_name[m3inv_pkg::NELEM] = '{"r11", "r12", "r13", "r21", "r22", "r23",
                                               "r31", "r32", "r33"};

        function new();
            thr = m3inv_pkg::THR_RESET;
        endfunction

        function m3inv_pkg::result_t inverse_of(m3inv_pkg::matrix_t m);
            longint e[m3inv_pkg::NELEM];
            longint adj[m3inv_pkg::NELEM];
            longint c11, c21, c31, c12, c13, c22, c23, c32, c33;
            logic signed [127:0] det;
            logic [127:0] dmag, num, q, lim_v, bound;
            logic [63:0] mag;
            logic [31:0] r[m3inv_pkg::NELEM];
            logic neg, sat;
            m3inv_pkg::result_t res;
            e = '{m.a11, m.a12, m.a13, m.a21, m.a22, m.a23, m.a31, m.a32, m.a33};
            // 64-bit minors wrap exactly as two's complement
            c11 = e[4] * e[8] - e[5] * e[7];
            c21 = e[1] * e[8] - e[2] * e[7];
            c31 = e[1] * e[5] - e[2] * e[4];
            c12 = e[3] * e[8] - e[5] * e[6];
            c13 = e[3] * e[7] - e[4] * e[6];
            c22 = e[0] * e[8] - e[2] * e[6];
            c23 = e[0] * e[7] - e[1] * e[6];
            c32 = e[0] * e[5] - e[2] * e[3];
            c33 = e[0] * e[4] - e[1] * e[3];
            det = 128'(signed'(e[0])) * 128'(signed'(c11))
                - 128'(signed'(e[3])) * 128'(signed'(c21))
                + 128'(signed'(e[6])) * 128'(signed'(c31));
            adj = '{c11, -c21, c31, -c12, c22, -c32, c13, -c23, c33};
            dmag = det[127] ? 128'(-det) : 128'(det);
            lim_v = {97'd0, thr} << (2 * FB);
            sat = 1'b0;
            if (lim_v >= dmag) begin
                res = '{r11: m.a11, r12: m.a12, r13: m.a13, r21: m.a21, r22: m.a22,
                        r23: m.a23, r31: m.a31, r32: m.a32, r33: m.a33,
                        singular: 1'b1, saturated: 1'b0};
                return res;
            end
            for (int k = 0; k < m3inv_pkg::NELEM; k++) begin
                mag = (adj[k] < 0) ? 64'(-adj[k]) : 64'(adj[k]);
                num = {64'd0, mag} << (2 * FB);
                // round half away from zero on the magnitude
                q = ((num << 1) + dmag) / (dmag << 1);
                neg = (adj[k] < 0) != det[127];
                bound = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
                if (q > bound) begin
                    sat = 1'b1;
                    q = bound;
                end
                r[k] = neg ? 32'(-q) : q[31:0];
            end
            res = '{r11: r[0], r12: r[1], r13: r[2], r21: r[3], r22: r[4], r23: r[5],
                    r31: r[6], r32: r[7], r33: r[8], singular: 1'b0, saturated: sat};
            return res;
        endfunction

        function void note_matrix(m3inv_pkg::matrix_t m);
            expected_q.push_back(inverse_of(m));
        endfunction

        function void check_result(m3inv_pkg::result_t got);
            m3inv_pkg::result_t want;
            logic [31:0] w, g;
            if (expected_q.size() == 0) begin
                $error("unexpected result beat, nothing outstanding");
                n_errors++;
                return;
            end
            want = expected_q.pop_front();
            n_checked++;
            if (want.singular) n_singular++;
            if (want.saturated) n_saturated++;
            for (int k = 0; k < m3inv_pkg::NELEM; k++) begin
                w = want[2 + 32 * (8 - k) +: 32];
                g = got[2 + 32 * (8 - k) +: 32];
                if (w !== g) begin
                    $error("%s: expected %h, got %h", elem_name[k], w, g);
                    n_errors++;
                end
            end
            if (want.singular !== got.singular) begin
                $error("singular: expected %b, got %b", want.singular, got.singular);
                n_errors++;
            end
            if (want.saturated !== got.saturated) begin
                $error("saturated: expected %b, got %b", want.saturated, got.saturated);
                n_errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic threshold_we = 1'b0;
    logic [m3inv_pkg::THR_W-1:0] threshold = '0;
    logic push = 1'b0;
    logic full;
    m3inv_pkg::matrix_t matrix = '0;
    logic pop = 1'b0;
    logic empty;
    m3inv_pkg::result_t result;

    inverse_scoreboard sb = new();
    int n_sent;
    int burst_left;
    int stall_mode;
    int stall_left;

    always #2 clk = ~clk;

    matrix3x3_inverse_top #(.FRAC_BITS(FB)) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .threshold_we(threshold_we),
        .threshold(threshold),
        .push(push),
        .full(full),
        .matrix(matrix),
        .pop(pop),
        .empty(empty),
        .result(result)
    );

    // receiver: switch between no stall, light and heavy stall
    always @(negedge clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 2);
            stall_left <= $urandom_range(10, 80);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            default: pop <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n && pop && !empty)
            sb.check_result(result);
    end

    task automatic send_matrix(m3inv_pkg::matrix_t m);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge clk);
                push <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        push <= 1'b1;
        matrix <= m;
        do @(posedge clk); while (full);
        sb.note_matrix(m);
        n_sent++;
    endtask

    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        // hold past the pipeline depth before touching the register
        repeat (60) @(posedge clk);
    endtask

    task automatic write_threshold(logic [m3inv_pkg::THR_W-1:0] v);
        @(negedge clk);
        threshold_we <= 1'b1;
        threshold <= v;
        @(negedge clk);
        threshold_we <= 1'b0;
        sb.thr = v;
    endtask

    function automatic logic signed [31:0] small_elem(int span);
        return $signed($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic m3inv_pkg::matrix_t random_matrix();
        m3inv_pkg::matrix_t m;
        int kind;
        int span;
        kind = $urandom_range(0, 9);
        span = 1 << $urandom_range(8, 20);
        m.a11 = small_elem(span); m.a12 = small_elem(span); m.a13 = small_elem(span);
        m.a21 = small_elem(span); m.a22 = small_elem(span); m.a23 = small_elem(span);
        m.a31 = small_elem(span); m.a32 = small_elem(span); m.a33 = small_elem(span);
        case (kind)
            0, 1:
            begin
                m.a11 = $urandom(); m.a12 = $urandom(); m.a13 = $urandom();
                m.a21 = $urandom(); m.a22 = $urandom(); m.a23 = $urandom();
                m.a31 = $urandom(); m.a32 = $urandom(); m.a33 = $urandom();
            end
            2, 3, 4:
            begin
                // diagonally dominant, well conditioned
                m.a11 = m.a11 + 4 * span;
                m.a22 = m.a22 - 4 * span;
                m.a33 = m.a33 + 4 * span;
            end
            5:
            begin
                // repeated row, determinant zero
                m.a31 = m.a11; m.a32 = m.a12; m.a33 = m.a13;
            end
            6:
            begin
                m.a11 = $urandom(); m.a22 = $urandom(); m.a33 = $urandom();
            end
            default: ;
        endcase
        return m;
    endfunction

    task automatic run_directed();
        m3inv_pkg::matrix_t m;
        m = '{a11: 32'h10000, a22: 32'h10000, a33: 32'h10000, default: 32'sd0};
        send_matrix(m);
        send_matrix('0);
        send_matrix('{default: 32'sh7FFF_FFFF});
        send_matrix('{default: 32'sh8000_0000});
        m = '{a11: 32'sh8000_0000, a22: 32'sh8000_0000, a33: 32'sh8000_0000,
              default: 32'sd0};
        send_matrix(m);
        m = '{a11: 32'sh7FFF_FFFF, a22: 32'sh8000_0000, a33: 32'sh7FFF_FFFF,
              default: 32'sd0};
        send_matrix(m);
        // tiny diagonal: inverse far beyond range
        m = '{a11: 32'sd1, a22: 32'sd1, a33: 32'sd1, default: 32'sd0};
        send_matrix(m);
        m = '{a11: 32'sd256, a22: -32'sd256, a33: 32'sd256, default: 32'sd0};
        send_matrix(m);
        m = '{a11: 32'sh20000, a12: 32'sh10000, a13: 32'sd0,
              a21: 32'sh10000, a22: 32'sh20000, a23: 32'sh10000,
              a31: 32'sd0, a32: 32'sh10000, a33: 32'sh20000};
        send_matrix(m);
        // off-diagonal permutation with negative entries
        m = '{a13: -32'sh10000, a21: 32'sh30000, a32: -32'sh8000, default: 32'sd0};
        send_matrix(m);
        m = '{a11: 32'sh8000_0000, a12: 32'sh7FFF_FFFF, a13: 32'sh8000_0000,
              a21: 32'sh7FFF_FFFF, a22: 32'sh8000_0000, a23: 32'sh7FFF_FFFF,
              a31: 32'sh8000_0000, a32: 32'sh7FFF_FFFF, a33: 32'sh7FFF_FFFF};
        send_matrix(m);
        m = '{a11: 32'sh8000_0000, a12: 32'sh8000_0000, a21: 32'sh8000_0000,
              a22: 32'sh7FFF_FFFF, a33: 32'sh10000, default: 32'sd0};
        send_matrix(m);
        m = '{a11: -32'sd1, a12: 32'sd1, a13: -32'sd1, a21: 32'sd1, a22: 32'sd1,
              a23: 32'sd1, a31: 32'sd1, a32: -32'sd1, a33: -32'sd1};
        send_matrix(m);
    endtask

    initial begin
        logic [m3inv_pkg::THR_W-1:0] phase_thr[6];
        burst_left = 0;
        n_sent = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        // reset threshold of one first, then zero, the top end, one, a random value, 65536 and a random value
        run_directed();
        phase_thr = '{31'd0, THR_MAX, 31'd1, m3inv_pkg::THR_W'($urandom() >> 1), 31'd65536,
                      m3inv_pkg::THR_W'($urandom_range(0, 1 << 20))};
        for (int p = 0; p < 6; p++) begin
            drain();
            write_threshold(phase_thr[p]);
            if (p < 2) run_directed();
            for (int i = 0; i < 320; i++) send_matrix(random_matrix());
        end
        drain();
        $display("Sent %0d matrices over 7 threshold settings; checked %0d results",
                 n_sent, sb.n_checked);
        $display("  %0d singular, %0d saturated", sb.n_singular, sb.n_saturated);
        if (sb.n_errors == 0 && sb.expected_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #2ms;
        $display("Regression FAIL");
        $finish;
    end
endmodule
